/* rtl/mzr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_pkg: shared definitions of the move-to-front zero-run decoder
// Sizes, derived widths and the control bundle the alphabet chain receives.
// ----------------------------------------------------------------------------
package mzr_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int RUN_WIDTH     = 32;

  localparam int SYM_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 32;

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int DP_W  = $clog2(RUN_WIDTH + 1);
  localparam int ACC_W = RUN_WIDTH + 2;

  // symbols below this value are run digits
  localparam logic [SYM_W-1:0] SYM_FIRST_BYTE = SYM_W'(2);
  localparam logic [SYM_W-1:0] SYM_MAX        = SYM_W'(ALPHABET_SIZE);

  typedef struct packed {
    logic             upd;  // move entry idx to the front
    logic             clr;  // return every cell to its initial value
    logic [IDX_W-1:0] idx;
  } mzr_cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/mzr_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_cell: one alphabet position
// Holds one byte XORed with its own position, so reset is all zeros.
// On a move it takes the value of its left neighbor when at or before idx.
// ----------------------------------------------------------------------------
module mzr_cell
  import mzr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [IDX_W-1:0]      pos_i,
  input  wire mzr_cell_ctrl_t        ctrl_i,
  input  wire logic [BYTE_W-1:0]     prev_i,
  output logic      [BYTE_W-1:0]     value_o,
  output logic      [BYTE_W-1:0]     sel_o
);

  logic [BYTE_W-1:0] delta_q, delta_d;
  logic [BYTE_W-1:0] pos_byte;
  logic              hit;
  logic              shift;

  assign pos_byte = BYTE_W'(pos_i);
  assign value_o  = delta_q ^ pos_byte;
  assign hit      = (pos_i == ctrl_i.idx);
  assign shift    = (pos_i <= ctrl_i.idx);
  assign sel_o    = hit ? value_o : '0;

  always_comb begin
    delta_d = delta_q;
    if (ctrl_i.clr) begin
      delta_d = '0;
    end else if (ctrl_i.upd && shift) begin
      delta_d = prev_i ^ pos_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
    end else begin
      delta_q <= delta_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/mzr_alphabet.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_alphabet: chain of alphabet cells
// Row of cells, each handing its byte to the right on a move-to-front, with
// an or-tree that picks out the selected entry.
// ----------------------------------------------------------------------------
module mzr_alphabet
  import mzr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mzr_cell_ctrl_t    ctrl_i,
  output logic [BYTE_W-1:0]      front_o,
  output logic [BYTE_W-1:0]      chosen_o
);

  logic [BYTE_W-1:0] value [ALPHABET_SIZE];
  logic [BYTE_W-1:0] sel   [ALPHABET_SIZE];
  logic [BYTE_W-1:0] prev  [ALPHABET_SIZE];

  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = chosen_o;
    end else begin : g_body
      assign prev[i] = value[i-1];
    end

    mzr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pos_i   (IDX_W'(i)),
      .ctrl_i  (ctrl_i),
      .prev_i  (prev[i]),
      .value_o (value[i]),
      .sel_o   (sel[i])
    );
  end

  // only the addressed cell drives a nonzero selection
  always_comb begin
    chosen_o = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      chosen_o = chosen_o | sel[i];
    end
  end

  assign front_o = value[0];

endmodule
`default_nettype wire

/* rtl/mzr_run.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mzr_run: zero-run accumulator
// Adds bijective base-2 digits with a doubling weight, saturating at the
// largest count.
// ----------------------------------------------------------------------------
module mzr_run
  import mzr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 digit_i,
  input  wire logic                 clear_i,
  output logic [RUN_WIDTH-1:0]      run_o,
  output logic [RUN_WIDTH-1:0]      run_next_o,
  output logic                      pending_o
);

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [RUN_WIDTH-1:0] run_q, run_d;
  logic [DP_W-1:0]      dp_q, dp_d;
  logic [ACC_W-1:0]     weight;
  logic [ACC_W-1:0]     acc;
  logic                 room;

  assign room   = (dp_q < DP_W'(RUN_WIDTH));
  assign weight = ACC_W'({digit_i, ~digit_i}) << dp_q;
  assign acc    = ACC_W'(run_q) + weight;

  always_comb begin
    if (!room || (acc > ACC_W'(RUN_MAX))) begin
      run_next_o = RUN_MAX;
    end else begin
      run_next_o = acc[RUN_WIDTH-1:0];
    end
  end

  always_comb begin
    run_d = run_q;
    dp_d  = dp_q;
    if (clear_i) begin
      run_d = '0;
      dp_d  = '0;
    end else if (step_i) begin
      run_d = run_next_o;
      if (room) begin
        dp_d = dp_q + DP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      dp_q  <= '0;
    end else begin
      run_q <= run_d;
      dp_q  <= dp_d;
    end
  end

  assign run_o     = run_q;
  assign pending_o = (dp_q != '0);

endmodule
`default_nettype wire

/* rtl/mtf_zero_run_decoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_zero_run_decoder: move-to-front decoder with bijective zero runs
// Turns entropy-decoded symbols into (byte, repeat count) transactions.
// ----------------------------------------------------------------------------
// One symbol is taken per cycle whenever the output register can take its
// results and no second result is held. A symbol that causes two results
// (pending run flush followed by the selected byte) parks the second one in
// a holding register, so input stalls after it while that result drains.
// The alphabet lives in a row of 256 cells; the cells at or before the
// selected entry shift in the same cycle as the symbol is accepted, and the
// selected entry is picked by an or-tree over the cells. Run digits produce
// no output unless they close a block. A block end restores the alphabet and
// clears the run in the same cycle.
// ----------------------------------------------------------------------------
module mtf_zero_run_decoder
  import mzr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [SYM_W-1:0]    symbol_i,
  input  wire logic                block_end_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [BYTE_W-1:0]        byte_value_o,
  output logic [COUNT_W-1:0]       repeat_count_o,
  output logic                     last_o
);

  logic                 accept;
  logic                 is_digit;
  logic [SYM_W-1:0]     sym_c;
  mzr_cell_ctrl_t       cell_ctrl;
  logic [BYTE_W-1:0]    front;
  logic [BYTE_W-1:0]    chosen;
  logic [RUN_WIDTH-1:0] run;
  logic [RUN_WIDTH-1:0] run_next;
  logic                 pending;
  logic                 out_free;

  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    out_byte_q, out_byte_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;
  logic                 out_last_q, out_last_d;
  logic                 hold_valid_q, hold_valid_d;
  logic [BYTE_W-1:0]    hold_byte_q, hold_byte_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free && !hold_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (symbol_i < SYM_FIRST_BYTE);
  assign sym_c      = (symbol_i > SYM_MAX) ? SYM_MAX : symbol_i;

  always_comb begin
    cell_ctrl.upd = accept && !is_digit;
    cell_ctrl.clr = accept && block_end_i;
    cell_ctrl.idx = IDX_W'(sym_c - SYM_W'(1));
  end

  mzr_alphabet u_alphabet (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (cell_ctrl),
    .front_o  (front),
    .chosen_o (chosen)
  );

  mzr_run u_run (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept && is_digit),
    .digit_i    (symbol_i[0]),
    .clear_i    (accept && (block_end_i || !is_digit)),
    .run_o      (run),
    .run_next_o (run_next),
    .pending_o  (pending)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    if (out_free) begin
      if (hold_valid_q) begin
        out_valid_d  = 1'b1;
        out_byte_d   = hold_byte_q;
        out_count_d  = COUNT_W'(1);
        out_last_d   = 1'b1;
        hold_valid_d = 1'b0;
      end else if (accept && is_digit && block_end_i) begin
        // block closes on a run: flush it with the new digit included
        out_valid_d = 1'b1;
        out_byte_d  = front;
        out_count_d = COUNT_W'(run_next);
        out_last_d  = 1'b1;
      end else if (accept && !is_digit && pending) begin
        out_valid_d  = 1'b1;
        out_byte_d   = front;
        out_count_d  = COUNT_W'(run);
        out_last_d   = 1'b0;
        hold_valid_d = 1'b1;
        hold_byte_d  = chosen;
      end else if (accept && !is_digit) begin
        out_valid_d = 1'b1;
        out_byte_d  = chosen;
        out_count_d = COUNT_W'(1);
        out_last_d  = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    hold_byte_q <= hold_byte_d;
  end

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = out_byte_q;
  assign repeat_count_o = out_count_q;
  assign last_o         = out_last_q;

  // a queued second result always sits behind a visible first one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> out_valid_q)
    else $error("holding register filled while output slot empty");

  // a non-final result always has its byte queued behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> hold_valid_q)
    else $error("non-final result without its byte queued behind it");

  // a pending run always carries a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending |-> (run != '0))
    else $error("pending run with zero count");

  // a digit that does not close a block leaves the output untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_digit && !block_end_i && !out_valid_q) |=> !out_valid_q)
    else $error("run digit produced a result");

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the move-to-front zero-run decoder
// Drives symbol transactions through valid/ready with random gaps and
// backpressure. A behavioral copy of the alphabet and run state predicts each
// (byte, repeat count, last) transaction, and a monitor compares it in order.
// ----------------------------------------------------------------------------
module tb;
  import mzr_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          HOLD_OFF_LEN   = 250;
  localparam logic [63:0] RUN_SAT        = (64'd1 << RUN_WIDTH) - 64'd1;
  localparam int          SYM_TOP        = (1 << SYM_W) - 1;

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               last;
  } byte_run_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [SYM_W-1:0]   symbol_i       = '0;
  logic               block_end_i    = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [BYTE_W-1:0]  byte_value_o;
  logic [COUNT_W-1:0] repeat_count_o;
  logic               last_o;

  // behavioral decoder state
  logic [BYTE_W-1:0]  mtf_table [ALPHABET_SIZE];
  logic [COUNT_W-1:0] run_len;
  int unsigned        run_digits;
  byte_run_t          byte_runs_due[$];

  int unsigned mismatch_cnt    = 0;
  int unsigned stall_cycles    = 0;
  int unsigned hold_off_cycles = 0;
  bit          steady          = 1'b0;

  mtf_zero_run_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .symbol_i       (symbol_i),
    .block_end_i    (block_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_value_o   (byte_value_o),
    .repeat_count_o (repeat_count_o),
    .last_o         (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SYM_W-1:0] pick_byte_symbol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return SYM_W'($urandom_range(2, 9));
    if (r < 92) return SYM_W'($urandom_range(2, ALPHABET_SIZE));
    return SYM_W'($urandom_range(ALPHABET_SIZE + 1, SYM_TOP));
  endfunction

  task automatic clear_alphabet();
    for (int i = 0; i < ALPHABET_SIZE; i++) mtf_table[i] = BYTE_W'(i);
    run_len    = '0;
    run_digits = 0;
  endtask

  // advance the alphabet and run state by one symbol, queue what it yields
  task automatic mtf_decode_step(input logic [SYM_W-1:0] sym, input logic eob);
    logic [63:0]       acc;
    int unsigned       pos;
    logic [BYTE_W-1:0] pick;
    if (sym < SYM_FIRST_BYTE) begin
      acc = {{(64-COUNT_W){1'b0}}, run_len};
      if (run_digits < RUN_WIDTH) begin
        acc = acc + ((64'(sym) + 64'd1) << run_digits);
        if (acc > RUN_SAT) acc = RUN_SAT;
        run_digits++;
      end else begin
        acc = RUN_SAT;
      end
      run_len = acc[COUNT_W-1:0];
      if (eob) byte_runs_due.push_back('{mtf_table[0], run_len, 1'b1});
    end else begin
      pos = (sym > SYM_MAX) ? ALPHABET_SIZE - 1 : int'(sym) - 1;
      if (run_digits != 0) begin
        byte_runs_due.push_back('{mtf_table[0], run_len, 1'b0});
        run_len    = '0;
        run_digits = 0;
      end
      pick = mtf_table[pos];
      byte_runs_due.push_back('{pick, COUNT_W'(1), 1'b1});
      for (int j = pos; j > 0; j--) mtf_table[j] = mtf_table[j-1];
      mtf_table[0] = pick;
    end
    if (eob) clear_alphabet();
  endtask

  // valid stays up between back-to-back transactions
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic eob);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    symbol_i    <= sym;
    block_end_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    mtf_decode_step(sym, eob);
  endtask

  // runs of digits closed by a byte symbol, with the odd block end anywhere
  task automatic send_mixed(input int unsigned count);
    int unsigned sent, run, k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 1) == 0) run = 0;
      else if ($urandom_range(0, 19) == 0) run = $urandom_range(10, 40);
      else run = $urandom_range(1, 5);
      for (k = 0; k < run; k++) begin
        send_item(SYM_W'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
        sent++;
      end
      send_item(pick_byte_symbol(), $urandom_range(0, 24) == 0);
      sent++;
    end
  endtask

  task automatic log_mismatch(input string why, input byte_run_t want,
                              input byte_run_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: expected value %0d count %0d last %0b, got value %0d count %0d last %0b",
               $realtime, why, want.value, want.count, want.last,
               got.value, got.count, got.last);
  endtask

  task automatic test_directed();
    send_item(SYM_W'(2), 1'b0);          // second entry, just behind the front
    send_item(SYM_MAX, 1'b0);            // last position
    send_item(SYM_W'(SYM_TOP), 1'b0);    // beyond the alphabet
    send_item(SYM_W'(257), 1'b0);
    send_item(SYM_W'(0), 1'b0);          // single digit run, then a byte
    send_item(SYM_W'(5), 1'b0);
    send_item(SYM_W'(1), 1'b0);
    send_item(SYM_W'(0), 1'b0);
    send_item(SYM_W'(1), 1'b0);
    send_item(SYM_W'(3), 1'b1);          // run flush plus byte on block end
    send_item(SYM_W'(0), 1'b1);          // run flushed by block end alone
    send_item(SYM_W'(1), 1'b0);
    send_item(SYM_W'(1), 1'b1);
    send_item(SYM_W'(2), 1'b1);          // block end with nothing pending
    send_item(SYM_W'(130), 1'b0);
    send_item(SYM_W'(130), 1'b0);
    send_item(SYM_W'(2), 1'b0);
    send_item(SYM_W'(0), 1'b0);
    send_item(SYM_MAX, 1'b0);
    send_item(SYM_W'(SYM_TOP - 1), 1'b1);
  endtask

  // enough digits to saturate the run and stop the digit position
  task automatic test_long_runs();
    int unsigned len;
    for (int r = 0; r < 4; r++) begin
      len = $urandom_range(32, 40);
      for (int k = 0; k < len; k++) begin
        if (r == 0) send_item(SYM_W'(1), 1'b0);
        else if (r == 1) send_item(SYM_W'(0), k == len - 1);
        else send_item(SYM_W'($urandom_range(0, 1)), 1'b0);
      end
      if (r != 1) send_item(pick_byte_symbol(), r == 3);
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = HOLD_OFF_LEN;
    send_mixed(30);
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    send_mixed(60);
    steady = 1'b0;
  endtask

  task automatic test_random_blocks();
    send_mixed(300);
  endtask

  // result sink: random stalls, steady stretches and one long hold-off
  initial begin : ready_driver
    int unsigned gap;
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else begin
        gap = steady ? 0 : idle_len();
        if (gap == 0) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    byte_run_t want;
    byte_run_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{byte_value_o, repeat_count_o, last_o};
      if (byte_runs_due.size() == 0) begin
        log_mismatch("unexpected transaction", '0, got);
      end else begin
        want = byte_runs_due.pop_front();
        if (got.value != want.value || got.count != want.count ||
            got.last != want.last)
          log_mismatch("mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_alphabet();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_steady_stream();
    test_long_runs();
    test_random_blocks();

    in_valid_i <= 1'b0;
    while (byte_runs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && byte_runs_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
